// ===== rtl/core/height_grid_bilinear_sampler_top_assert.svh =====
// Assertion macros for the height grid sampler checker.
`ifndef HEIGHT_GRID_BILINEAR_SAMPLER_TOP_ASSERT_SVH
`define HEIGHT_GRID_BILINEAR_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HGBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("height grid sampler check failed");

// Next-cycle implication, disabled while reset is low.
`define HGBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("height grid sampler check failed");

`endif

// ===== rtl/core/hgbs_pkg.sv =====
// Shared types, constants and helpers for the height grid sampler.
`default_nettype none
package hgbs_pkg;

  // Grid geometry
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int DEPTH     = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W    = $clog2(DEPTH);

  // Field widths
  localparam int POS_W  = 14;
  localparam int FRAC_W = 8;
  localparam int INT_W  = POS_W - FRAC_W;
  localparam int HGT_W  = 16;
  localparam int ACC_W  = HGT_W + 2 * FRAC_W + 2;

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [INT_W:0]             cidx_t;   // one spare bit for the grid size
  typedef logic [FRAC_W-1:0]          frac_t;
  typedef logic [FRAC_W:0]            wfac_t;   // 0..256
  typedef logic [2*FRAC_W+1:0]        weight_t; // 0..65536
  typedef logic signed [HGT_W-1:0]    height_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam cidx_t COLS_C = cidx_t'(GRID_COLS);
  localparam cidx_t ROWS_C = cidx_t'(GRID_ROWS);
  localparam wfac_t W_ONE  = wfac_t'(1 << FRAC_W);

  // Operation and status codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_RANGE  = 1'b1;

  // Corner order of a sample: (x,y), (x+1,y), (x,y+1), (x+1,y+1)
  typedef enum logic [1:0] {
    CORNER_00 = 2'd0,
    CORNER_10 = 2'd1,
    CORNER_01 = 2'd2,
    CORNER_11 = 2'd3
  } corner_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    rd_en;
    corner_t rd_corner;
    logic    acc_en;
    logic    out_load;
  } hgbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_err;
    logic item_write;
    logic out_busy;
  } hgbs_stat_t;

  // Address offset of a corner from the base cell
  function automatic addr_t corner_offset(corner_t c);
    addr_t off;
    case (c)
      CORNER_00: off = '0;
      CORNER_10: off = addr_t'(1);
      CORNER_01: off = addr_t'(GRID_COLS);
      CORNER_11: off = addr_t'(GRID_COLS + 1);
      default:   off = '0;
    endcase
    return off;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hgbs_ctrl.sv =====
// FSM: accept, four corner reads, drain (samples only), result handoff.
`default_nettype none
module hgbs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire hgbs_pkg::hgbs_stat_t stat,
  output hgbs_pkg::hgbs_cmd_t     cmd
);
  import hgbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t  state_r;
  corner_t corner_r;
  logic    acc_en_r;

  // Command decode
  assign in_stall      = (state_r != S_IDLE);
  assign cmd.accept    = (state_r == S_IDLE) && in_valid;
  assign cmd.rd_en     = (state_r == S_READ);
  assign cmd.rd_corner = corner_r;
  assign cmd.acc_en    = acc_en_r;
  assign cmd.out_load  = (state_r == S_DONE) && !stat.out_busy;

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= CORNER_00;
      acc_en_r <= 1'b0;
    end else begin
      // read data is registered and accumulated in the cycle after the read
      acc_en_r <= (state_r == S_READ);
      case (state_r)
        S_IDLE: begin
          corner_r <= CORNER_00;
          if (in_valid) begin
            if (stat.item_err || stat.item_write) state_r <= S_DONE;
            else                                  state_r <= S_READ;
          end
        end
        S_READ: begin
          corner_r <= corner_t'(corner_r + 2'd1);
          if (corner_r == CORNER_11) state_r <= S_DRAIN;
        end
        S_DRAIN: state_r <= S_DONE;
        S_DONE: begin
          if (!stat.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/hgbs_datapath.sv =====
// Height memory, corner weighting, accumulation and output register.
`default_nettype none
module hgbs_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_operation,
  input  wire hgbs_pkg::pos_t       in_x_pos,
  input  wire hgbs_pkg::pos_t       in_y_pos,
  input  wire hgbs_pkg::height_t    in_height_value,
  input  wire hgbs_pkg::hgbs_cmd_t  cmd,
  output hgbs_pkg::hgbs_stat_t      stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output hgbs_pkg::height_t         out_sampled_height,
  output logic                      out_status
);
  import hgbs_pkg::*;

  logic [HGT_W-1:0] mem_r [DEPTH];

  cidx_t   mx, my;
  logic    is_write, item_err;
  addr_t   base;
  addr_t   mem_addr;
  logic    wr_en;

  addr_t   base_r;
  frac_t   dx_r, dy_r;
  logic    err_r, wr_r;
  height_t rdata_r;
  weight_t w_r;
  weight_t w_nxt;
  wfac_t   wx, wy;
  acc_t    acc_r;
  acc_t    prod;
  acc_t    quo;
  acc_t    res_full;
  logic    neg_frac;
  logic    out_valid_r;
  height_t out_height_r;
  logic    out_status_r;

  // Cell index and range check of the incoming beat
  assign mx       = cidx_t'(in_x_pos[POS_W-1:FRAC_W]);
  assign my       = cidx_t'(in_y_pos[POS_W-1:FRAC_W]);
  assign is_write = (in_operation == OP_WRITE);
  always_comb begin
    if (is_write) item_err = (mx >= COLS_C) || (my >= ROWS_C);
    else          item_err = (mx + cidx_t'(1) >= COLS_C) || (my + cidx_t'(1) >= ROWS_C);
  end
  assign base = addr_t'(my * GRID_COLS) + addr_t'(mx);

  assign stat.item_err   = item_err;
  assign stat.item_write = is_write;
  assign stat.out_busy   = out_valid_r && out_stall;

  // Single memory port: write on accept, corner reads afterward
  assign wr_en    = cmd.accept && is_write && !item_err;
  assign mem_addr = cmd.accept ? base : base_r + corner_offset(cmd.rd_corner);

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[mem_addr] <= in_height_value;
    if (cmd.rd_en) rdata_r <= height_t'(mem_r[mem_addr]);
  end

  // Bilinear weight of the corner being read
  always_comb begin
    wx = cmd.rd_corner[0] ? wfac_t'(dx_r) : W_ONE - wfac_t'(dx_r);
    wy = cmd.rd_corner[1] ? wfac_t'(dy_r) : W_ONE - wfac_t'(dy_r);
    w_nxt = weight_t'(wx) * weight_t'(wy);
  end

  // Weighted sum of the four corners
  assign prod = acc_t'(rdata_r) * acc_t'({1'b0, w_r});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_r <= base;
      dx_r   <= in_x_pos[FRAC_W-1:0];
      dy_r   <= in_y_pos[FRAC_W-1:0];
      err_r  <= item_err;
      wr_r   <= is_write;
      acc_r  <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + prod;
    end
    if (cmd.rd_en) w_r <= w_nxt;
  end

  // Divide by 2^16, truncating toward zero
  assign quo      = acc_r >>> (2 * FRAC_W);
  assign neg_frac = acc_r[ACC_W-1] && (acc_r[2*FRAC_W-1:0] != '0);
  assign res_full = quo + acc_t'({1'b0, neg_frac});

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_height_r <= (err_r || wr_r) ? '0 : height_t'(res_full[HGT_W-1:0]);
      out_status_r <= err_r ? ST_RANGE : ST_OK;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sampled_height = out_height_r;
  assign out_status         = out_status_r;

endmodule
`default_nettype wire

// ===== rtl/core/height_grid_bilinear_sampler_top.sv =====
// A write goes from accept straight to the result handoff; a sample first reads
//   its four corners through the single height memory port, one read per cycle.
//   The input stalls until the result enters the output register.
// An out-of-range item skips the reads; a held result delays the next handoff.
// Reset (rst_n low, synchronous) clears control state only; height cells
//   hold nothing defined until written.
`default_nettype none
module height_grid_bilinear_sampler_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_operation,
  input  wire hgbs_pkg::pos_t    in_x_pos,
  input  wire hgbs_pkg::pos_t    in_y_pos,
  input  wire hgbs_pkg::height_t in_height_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hgbs_pkg::height_t      out_sampled_height,
  output logic                   out_status
);
  import hgbs_pkg::*;

  hgbs_cmd_t  cmd;
  hgbs_stat_t stat;

  // Sequencer
  hgbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Memory and arithmetic
  hgbs_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_operation),
    .in_x_pos           (in_x_pos),
    .in_y_pos           (in_y_pos),
    .in_height_value    (in_height_value),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sampled_height (out_sampled_height),
    .out_status         (out_status)
  );

endmodule
`default_nettype wire

// ===== rtl/core/hgbs_checker.sv =====
// Port-level checks for the height grid sampler, bound to the top level.
`default_nettype none
`include "height_grid_bilinear_sampler_top_assert.svh"
module hgbs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire hgbs_pkg::height_t out_sampled_height,
  input wire logic              out_status
);
  import hgbs_pkg::*;

  // A held result beat stays valid
  `HGBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // A held result beat keeps its payload
  `HGBS_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(out_sampled_height) && $stable(out_status))
  // Range errors report zero height
  `HGBS_ASSERT_NOW(a_err_zero, out_valid && (out_status == ST_RANGE),
    out_sampled_height == '0)
  // One item in flight: an accepted beat stalls the input next cycle
  `HGBS_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

endmodule

bind height_grid_bilinear_sampler_top hgbs_checker u_hgbs_checker (.*);
`default_nettype wire
